@@ sv/octp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octp_pkg: shared types and constants of the octal debug console parser
// Event and target codes, console character codes, the event record and the
// bundle of events that one accepted item produces.
// ----------------------------------------------------------------------------
package octp_pkg;

  // Field widths of the result record
  localparam int LocW  = 18;
  localparam int WordW = 16;
  localparam int CharW = 8;

  // Default width of the typed number and of the open location
  localparam int AddrBitsDefault = 18;

  // Up to four events per item
  localparam int MaxEvents = 4;
  localparam int CntW      = $clog2(MaxEvents + 1);
  localparam int IdxW      = $clog2(MaxEvents);

  // Console character codes
  localparam logic [CharW-1:0] CH_LF      = 8'h0A;
  localparam logic [CharW-1:0] CH_CR      = 8'h0D;
  localparam logic [CharW-1:0] CH_ESC     = 8'h1B;
  localparam logic [CharW-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CharW-1:0] CH_DOT     = 8'h2E;
  localparam logic [CharW-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CharW-1:0] CH_0       = 8'h30;
  localparam logic [CharW-1:0] CH_7       = 8'h37;
  localparam logic [CharW-1:0] CH_G       = 8'h47;
  localparam logic [CharW-1:0] CH_P       = 8'h50;
  localparam logic [CharW-1:0] CH_R       = 8'h52;
  localparam logic [CharW-1:0] CH_S       = 8'h53;
  localparam logic [CharW-1:0] CH_GRAVE   = 8'h60;
  localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CharW-1:0] CASE_FOLD  = 8'h20;

  typedef enum logic [2:0] {
    EV_ECHO    = 3'd0,
    EV_READ    = 3'd1,
    EV_SHOW    = 3'd2,
    EV_WRITE   = 3'd3,
    EV_ERROR   = 3'd4,
    EV_PROMPT  = 3'd5,
    EV_NEWLINE = 3'd6,
    EV_RESUME  = 3'd7
  } ev_code_t;

  typedef enum logic [1:0] {
    TGT_MEM = 2'd0,
    TGT_REG = 2'd1,
    TGT_PSW = 2'd2
  } tgt_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MEM  = 2'd1,
    KIND_REG  = 2'd2,
    KIND_PSW  = 2'd3
  } kind_t;

  localparam logic [2:0] PC_REG = 3'd7;

  typedef struct packed {
    ev_code_t          code;
    tgt_t              target;
    logic [LocW-1:0]   location;
    logic [WordW-1:0]  word_value;
    logic [CharW-1:0]  echo_char;
  } ev_t;

  typedef struct packed {
    ev_t [MaxEvents-1:0] evs;
    logic [CntW-1:0]     count;
  } bundle_t;

  // Event with every payload field zero
  function automatic ev_t plain_ev(ev_code_t code);
    ev_t e;
    e      = '0;
    e.code = code;
    return e;
  endfunction

  // Echo event for a character
  function automatic ev_t echo_ev(logic [CharW-1:0] c);
    ev_t e;
    e           = plain_ev(EV_ECHO);
    e.echo_char = c;
    return e;
  endfunction

  // Append one event to a bundle
  function automatic bundle_t add_ev(bundle_t b, ev_t e);
    bundle_t r;
    r = b;
    if (r.count < CntW'(MaxEvents)) begin
      r.evs[r.count[IdxW-1:0]] = e;
      r.count                  = r.count + CntW'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/octp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octp_front: command decoder
// Accepts console characters and read responses, updates the parser state
// and builds the bundle of result events for each transfer combinationally.
// ----------------------------------------------------------------------------
module octp_front #(
  parameter int ADDR_BITS = octp_pkg::AddrBitsDefault
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     action,
  input  wire logic [octp_pkg::CharW-1:0] key_char,
  input  wire logic [octp_pkg::WordW-1:0] read_value,
  input  wire logic                     q_full,
  output logic                          q_push,
  output octp_pkg::bundle_t             q_data
);
  import octp_pkg::*;

  // Parser state
  logic [ADDR_BITS-1:0] typed_number;
  logic                 number_present;
  logic                 want_reg_digit;
  kind_t                open_kind;
  logic                 loc_open;
  logic [ADDR_BITS-1:0] open_location;
  logic                 read_outstanding;

  logic [ADDR_BITS-1:0] typed_number_next;
  logic                 number_present_next;
  logic                 want_reg_digit_next;
  kind_t                open_kind_next;
  logic                 loc_open_next;
  logic [ADDR_BITS-1:0] open_location_next;
  logic                 read_outstanding_next;

  logic           accept;
  logic [CharW-1:0] c;
  logic           is_digit;
  logic           write_due;
  bundle_t        res;

  // Access event for the opened word: registers wrap to 0..7, status has none
  function automatic ev_t access_ev(ev_code_t code, kind_t kind,
                                    logic [ADDR_BITS-1:0] loc,
                                    logic [WordW-1:0] val);
    logic [ADDR_BITS+LocW-1:0] wide;
    ev_t e;
    wide         = {{LocW{1'b0}}, loc};
    e            = plain_ev(code);
    e.word_value = val;
    case (kind)
      KIND_REG: begin
        e.target   = TGT_REG;
        e.location = LocW'(loc[2:0]);
      end
      KIND_PSW: begin
        e.target   = TGT_PSW;
        e.location = '0;
      end
      default: begin
        e.target   = TGT_MEM;
        e.location = wide[LocW-1:0];
      end
    endcase
    return e;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (res.count != '0);
  assign q_data   = res;

  // Decode one item; state updates follow the order of the command rules
  always_comb begin
    typed_number_next     = typed_number;
    number_present_next   = number_present;
    want_reg_digit_next   = want_reg_digit;
    open_kind_next        = open_kind;
    loc_open_next         = loc_open;
    open_location_next    = open_location;
    read_outstanding_next = read_outstanding;
    res                   = '0;
    c                     = key_char;
    is_digit              = 1'b0;
    write_due             = loc_open && number_present && (open_kind != KIND_NONE);

    if (action) begin
      // read response
      if (read_outstanding) begin
        read_outstanding_next = 1'b0;
        res = add_ev(res, access_ev(EV_SHOW, open_kind, open_location, read_value));
      end
    end else if (!read_outstanding) begin
      if (key_char == CH_ESC || key_char == CH_GRAVE) begin
        // immediate resume
        typed_number_next     = '0;
        number_present_next   = 1'b0;
        want_reg_digit_next   = 1'b0;
        open_kind_next        = KIND_NONE;
        loc_open_next         = 1'b0;
        open_location_next    = '0;
        read_outstanding_next = 1'b0;
        res = add_ev(res, plain_ev(EV_RESUME));
      end else begin
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_FOLD;
        if (c == CH_DOT) c = CH_LF;
        is_digit = (c >= CH_0) && (c <= CH_7);

        if (c == CH_R || c == CH_DOLLAR) begin
          // register prefix
          res = add_ev(res, echo_ev(c));
          want_reg_digit_next = 1'b1;
          number_present_next = 1'b0;
          typed_number_next   = '0;
          if (!loc_open) open_kind_next = KIND_NONE;
        end else if (want_reg_digit) begin
          // register digit or status selector
          res = add_ev(res, echo_ev(c));
          want_reg_digit_next = 1'b0;
          if (is_digit) begin
            typed_number_next   = ADDR_BITS'(c[2:0]);
            number_present_next = 1'b1;
            open_kind_next      = KIND_REG;
          end else if (c == CH_S) begin
            number_present_next = 1'b1;
            open_kind_next      = KIND_PSW;
          end else begin
            res = add_ev(res, plain_ev(EV_ERROR));
            res = add_ev(res, plain_ev(EV_PROMPT));
            typed_number_next   = '0;
            number_present_next = 1'b0;
            open_kind_next      = KIND_NONE;
            loc_open_next       = 1'b0;
          end
        end else if (is_digit) begin
          // octal digit shifts into the typed number
          res = add_ev(res, echo_ev(c));
          typed_number_next   = {typed_number[ADDR_BITS-4:0], c[2:0]};
          number_present_next = 1'b1;
          if (open_kind == KIND_REG && !loc_open) open_kind_next = KIND_NONE;
        end else if (c == CH_SLASH) begin
          // open a location and request its value
          res = add_ev(res, echo_ev(c));
          if (open_kind == KIND_REG && !loc_open) begin
            open_location_next = typed_number;
          end else if (open_kind == KIND_PSW && !loc_open) begin
            open_location_next = open_location;
          end else begin
            if (number_present) open_location_next = typed_number;
            open_kind_next = KIND_MEM;
          end
          loc_open_next = 1'b1;
          if (open_kind_next == KIND_MEM && open_location_next[0]) begin
            res = add_ev(res, plain_ev(EV_ERROR));
            res = add_ev(res, plain_ev(EV_PROMPT));
            open_kind_next = KIND_NONE;
            loc_open_next  = 1'b0;
          end else begin
            res = add_ev(res, access_ev(EV_READ, open_kind_next, open_location_next, '0));
            read_outstanding_next = 1'b1;
          end
          typed_number_next   = '0;
          number_present_next = 1'b0;
        end else if (c == CH_CR) begin
          // write and close
          res = add_ev(res, plain_ev(EV_NEWLINE));
          if (write_due) begin
            res = add_ev(res, access_ev(EV_WRITE, open_kind, open_location,
                                        typed_number[WordW-1:0]));
          end
          open_kind_next      = KIND_NONE;
          loc_open_next       = 1'b0;
          typed_number_next   = '0;
          number_present_next = 1'b0;
          res = add_ev(res, plain_ev(EV_PROMPT));
        end else if (c == CH_LF) begin
          // write and step to the next location; open with no kind is a no-op
          if (!(loc_open && open_kind == KIND_NONE)) begin
            res = add_ev(res, plain_ev(EV_NEWLINE));
            if (write_due) begin
              res = add_ev(res, access_ev(EV_WRITE, open_kind, open_location,
                                          typed_number[WordW-1:0]));
            end
            if (loc_open) begin
              if (open_kind == KIND_REG) begin
                // register number wraps within 0..7
                open_location_next = ADDR_BITS'(3'(open_location[2:0] + 3'd1));
                res = add_ev(res, access_ev(EV_READ, open_kind, open_location_next, '0));
                read_outstanding_next = 1'b1;
              end else if (open_kind == KIND_PSW) begin
                open_kind_next = KIND_NONE;
                loc_open_next  = 1'b0;
                res = add_ev(res, plain_ev(EV_PROMPT));
              end else begin
                open_location_next = open_location + ADDR_BITS'(2);
                if (open_location_next[0]) begin
                  res = add_ev(res, plain_ev(EV_ERROR));
                  res = add_ev(res, plain_ev(EV_PROMPT));
                  open_kind_next = KIND_NONE;
                  loc_open_next  = 1'b0;
                end else begin
                  res = add_ev(res, access_ev(EV_READ, open_kind, open_location_next, '0));
                  read_outstanding_next = 1'b1;
                end
              end
            end else begin
              res = add_ev(res, plain_ev(EV_PROMPT));
            end
            typed_number_next   = '0;
            number_present_next = 1'b0;
          end
        end else if (c == CH_G || c == CH_P) begin
          // go (optionally setting the program counter) or proceed
          res = add_ev(res, echo_ev(c));
          res = add_ev(res, plain_ev(EV_NEWLINE));
          if (c == CH_G && number_present) begin
            res = add_ev(res, access_ev(EV_WRITE, KIND_REG, ADDR_BITS'(PC_REG),
                                        typed_number[WordW-1:0]));
          end
          typed_number_next     = '0;
          number_present_next   = 1'b0;
          want_reg_digit_next   = 1'b0;
          open_kind_next        = KIND_NONE;
          loc_open_next         = 1'b0;
          open_location_next    = '0;
          read_outstanding_next = 1'b0;
          res = add_ev(res, plain_ev(EV_RESUME));
        end else begin
          // unknown character
          res = add_ev(res, echo_ev(c));
          res = add_ev(res, plain_ev(EV_ERROR));
          res = add_ev(res, plain_ev(EV_PROMPT));
          typed_number_next   = '0;
          number_present_next = 1'b0;
          want_reg_digit_next = 1'b0;
          open_kind_next      = KIND_NONE;
          loc_open_next       = 1'b0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      typed_number     <= '0;
      number_present   <= 1'b0;
      want_reg_digit   <= 1'b0;
      open_kind        <= KIND_NONE;
      loc_open         <= 1'b0;
      open_location    <= '0;
      read_outstanding <= 1'b0;
    end else if (accept) begin
      typed_number     <= typed_number_next;
      number_present   <= number_present_next;
      want_reg_digit   <= want_reg_digit_next;
      open_kind        <= open_kind_next;
      loc_open         <= loc_open_next;
      open_location    <= open_location_next;
      read_outstanding <= read_outstanding_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/octp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octp_queue: event bundle queue
// Two-entry queue of event bundles between the decoder and the output stage.
// ----------------------------------------------------------------------------
module octp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire octp_pkg::bundle_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output octp_pkg::bundle_t      head_data
);
  import octp_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int FillW = $clog2(Depth + 1);

  bundle_t          slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [FillW-1:0] fill;

  assign full       = (fill == FillW'(Depth));
  assign head_valid = (fill != '0);
  assign head_data  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + PtrW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + FillW'(1);
        2'b01:   fill <= fill - FillW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/octp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octp_back: event serializer
// Takes bundles from the queue and sends their events one per transfer
// through a registered output, marking the final event of each bundle.
// ----------------------------------------------------------------------------
module octp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire octp_pkg::bundle_t head_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output octp_pkg::ev_t          out_ev,
  output logic                   out_last
);
  import octp_pkg::*;

  bundle_t         cur;
  logic            cur_valid;
  logic [IdxW-1:0] idx;

  logic load;
  logic emit;
  logic is_last;
  logic take;

  assign load    = !out_valid || !out_stall;
  assign emit    = load && cur_valid;
  assign is_last = (CntW'(idx) + CntW'(1)) == cur.count;
  assign take    = !cur_valid || (emit && is_last);
  assign pop     = take && head_valid;

  // Current bundle and event index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      cur_valid <= head_valid;
      idx       <= '0;
    end else if (emit) begin
      idx <= idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head_data;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ev   <= cur.evs[idx];
      out_last <= is_last;
    end
  end

endmodule
`default_nettype wire

@@ sv/octal_debug_console_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octal_debug_console_parser: octal debugging console command parser
// Turns console characters and read responses into console events: echo,
// read request, show value, write, error, prompt, newline and resume.
// ----------------------------------------------------------------------------
// Each accepted transfer is decoded combinationally into zero to four events.
// A transfer that causes no event is absorbed without output. Events leave
// one per cycle from a registered output while it is not stalled; the output
// stage sets the sustained rate. A two-entry bundle queue sits between
// decoder and output stage, so input is taken every cycle while the queue
// has room, even while the output is stalled. The last output marks the
// final event of each input item.
module octal_debug_console_parser #(
  parameter int ADDR_BITS = octp_pkg::AddrBitsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       action,
  input  wire logic [octp_pkg::CharW-1:0] key_char,
  input  wire logic [octp_pkg::WordW-1:0] read_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [2:0]                      event_res,
  output logic [1:0]                      target,
  output logic [octp_pkg::LocW-1:0]       location,
  output logic [octp_pkg::WordW-1:0]      word_value,
  output logic [octp_pkg::CharW-1:0]      echo_char,
  output logic                            last
);
  import octp_pkg::*;

  logic    q_full;
  logic    q_push;
  bundle_t q_data;
  logic    q_pop;
  logic    q_head_valid;
  bundle_t q_head;
  ev_t     out_ev;

  octp_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .key_char  (key_char),
    .read_value(read_value),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  octp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_data (q_head)
  );

  octp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_head_valid),
    .head_data (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ev    (out_ev),
    .out_last  (last)
  );

  // Result fields
  assign event_res  = out_ev.code;
  assign target     = out_ev.target;
  assign location   = out_ev.location;
  assign word_value = out_ev.word_value;
  assign echo_char  = out_ev.echo_char;

endmodule
`default_nettype wire
